// File: hw/rtl/vigenere_cipher_with_metre_nulls_defines.svh
// Assertion macros shared by the cipher block.
`ifndef VIGENERE_CIPHER_WITH_METRE_NULLS_DEFINES_SVH
`define VIGENERE_CIPHER_WITH_METRE_NULLS_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define VCMN_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define VCMN_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: hw/rtl/vcmn_pkg.sv
// Package: shared types and constants of the metre-null Vigenere cipher.
package vcmn_pkg;

   // Fixed field and register widths.
   localparam int ALPHABET_W     = 6;
   localparam int KEY_LEN_REG_W  = 4;
   localparam int KEY_LETTERS_W  = 60;
   localparam int METRE_LEN_REG_W = 5;
   localparam int METRE_DIGITS_W = 64;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int DIGIT_W        = 4;
   localparam int SEP_W          = 2;

   localparam logic [DIGIT_W-1:0] NULLS_MAX = 4'd9;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_SIZE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LETTERS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_METRE_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_METRE_DIGITS  = 3'd4;

   // Separator codes.
   localparam logic [SEP_W-1:0] SEP_COMMA   = 2'd0;
   localparam logic [SEP_W-1:0] SEP_NEWLINE = 2'd1;
   localparam logic [SEP_W-1:0] SEP_NONE    = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_NULLS  = 3'b010,
      ST_LETTER = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic count;
      logic show_letter;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_ok;
      logic no_nulls;
      logic last_null;
   } sts_type;

endpackage

// File: hw/rtl/vcmn_ctrl.sv
// Controller: sequences the null tokens and the cipher letter of each request.
module vcmn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_token_kind,
   output logic              rsp_last,
   output vcmn_pkg::cmd_type cmd,
   input  vcmn_pkg::sts_type sts
);
   import vcmn_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new request is taken when idle or together with the letter's response.
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_LETTER) && rsp_ready);
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.load        = accept;
      cmd.show_letter = (state_ff == ST_LETTER);
      case (state_ff)
         ST_IDLE: begin
         end
         ST_NULLS: begin
            if (rsp_ready) begin
               cmd.count = 1'b1;
               if (sts.last_null) begin
                  state_in = ST_LETTER;
               end
            end
         end
         ST_LETTER: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept && sts.item_ok) begin
         state_in = sts.no_nulls ? ST_LETTER : ST_NULLS;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response flags decoded from the state.
   assign rsp_valid      = (state_ff == ST_NULLS) || (state_ff == ST_LETTER);
   assign rsp_token_kind = (state_ff == ST_LETTER);
   assign rsp_last       = (state_ff == ST_LETTER);

endmodule

// File: hw/rtl/vcmn_datapath.sv
// Datapath: configuration registers, key and metre positions, encipherment.
module vcmn_datapath #(
   parameter int MAX_KEY_LETTERS  = 10,
   parameter int MAX_METRE_DIGITS = 16,
   parameter int LETTER_BITS      = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [vcmn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vcmn_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [vcmn_pkg::ALPHABET_W-1:0]       req_letter_index,
   input  logic                                  req_end_of_message,
   output logic [vcmn_pkg::ALPHABET_W-1:0]       rsp_cipher_index,
   output logic [vcmn_pkg::SEP_W-1:0]            rsp_separator,
   input  vcmn_pkg::cmd_type                     cmd,
   output vcmn_pkg::sts_type                     sts
);
   import vcmn_pkg::*;

   localparam int KPOS_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
   localparam int MPOS_W = (MAX_METRE_DIGITS > 1) ? $clog2(MAX_METRE_DIGITS) : 1;
   localparam int KLEN_W = $clog2(MAX_KEY_LETTERS + 1);
   localparam int MLEN_W = $clog2(MAX_METRE_DIGITS + 1);

   // Configuration registers.
   logic [ALPHABET_W-1:0]      alphabet_size_ff;
   logic [KEY_LEN_REG_W-1:0]   key_length_ff;
   logic [KEY_LETTERS_W-1:0]   key_letters_ff;
   logic [METRE_LEN_REG_W-1:0] metre_length_ff;
   logic [METRE_DIGITS_W-1:0]  metre_digits_ff;

   // Positions and per-request result registers.
   logic [KPOS_W-1:0]  key_pos_ff;
   logic [KPOS_W-1:0]  key_pos_in;
   logic [MPOS_W-1:0]  metre_pos_ff;
   logic [MPOS_W-1:0]  metre_pos_in;
   logic [ALPHABET_W-1:0] cipher_ff;
   logic [ALPHABET_W-1:0] cipher_in;
   logic [SEP_W-1:0]   sep_ff;
   logic [SEP_W-1:0]   sep_in;
   logic [DIGIT_W-1:0] null_cnt_ff;
   logic [DIGIT_W-1:0] nulls_in;

   logic [LETTER_BITS-1:0] key_arr [MAX_KEY_LETTERS];
   logic [DIGIT_W-1:0]     digit_arr [MAX_METRE_DIGITS];

   logic [KLEN_W-1:0]     klen;
   logic [MLEN_W-1:0]     mlen;
   logic [KPOS_W-1:0]     kpos;
   logic [MPOS_W-1:0]     mpos;
   logic [KLEN_W-1:0]     kpos_inc;
   logic [MLEN_W-1:0]     mpos_inc;
   logic [ALPHABET_W-1:0] key_raw;
   logic [ALPHABET_W-1:0] key_val;
   logic [DIGIT_W-1:0]    digit;
   logic [ALPHABET_W:0]   sum;

   // Slice the packed key letters and metre digits.
   for (genvar g = 0; g < MAX_KEY_LETTERS; g++) begin : g_key
      assign key_arr[g] = key_letters_ff[g*LETTER_BITS +: LETTER_BITS];
   end
   for (genvar g = 0; g < MAX_METRE_DIGITS; g++) begin : g_digit
      assign digit_arr[g] = metre_digits_ff[g*DIGIT_W +: DIGIT_W];
   end

   // Effective lengths: zero acts as one, oversize saturates.
   always_comb begin
      if (key_length_ff == '0) begin
         klen = KLEN_W'(1);
      end else if (int'(key_length_ff) > MAX_KEY_LETTERS) begin
         klen = KLEN_W'(MAX_KEY_LETTERS);
      end else begin
         klen = KLEN_W'(key_length_ff);
      end
      if (metre_length_ff == '0) begin
         mlen = MLEN_W'(1);
      end else if (int'(metre_length_ff) > MAX_METRE_DIGITS) begin
         mlen = MLEN_W'(MAX_METRE_DIGITS);
      end else begin
         mlen = MLEN_W'(metre_length_ff);
      end
   end

   // Positions left beyond a shortened length restart at zero.
   assign kpos = (KLEN_W'(key_pos_ff) < klen) ? key_pos_ff : '0;
   assign mpos = (MLEN_W'(metre_pos_ff) < mlen) ? metre_pos_ff : '0;

   assign kpos_inc     = KLEN_W'(kpos) + KLEN_W'(1);
   assign mpos_inc     = MLEN_W'(mpos) + MLEN_W'(1);
   assign key_pos_in   = (kpos_inc >= klen) ? '0 : KPOS_W'(kpos_inc);
   assign metre_pos_in = (mpos_inc >= mlen) ? '0 : MPOS_W'(mpos_inc);

   // Key letter, with letters outside the alphabet taken as zero.
   assign key_raw = ALPHABET_W'(key_arr[kpos]);
   assign key_val = (key_raw >= alphabet_size_ff) ? '0 : key_raw;

   // Modular add: the sum stays below twice the modulus.
   assign sum       = {1'b0, req_letter_index} + {1'b0, key_val};
   assign cipher_in = (sum >= {1'b0, alphabet_size_ff})
                      ? ALPHABET_W'(sum - {1'b0, alphabet_size_ff})
                      : ALPHABET_W'(sum);

   // Null count saturates at nine.
   assign digit    = digit_arr[mpos];
   assign nulls_in = (digit > NULLS_MAX) ? NULLS_MAX : digit;

   // Separator after the letter.
   always_comb begin
      if (metre_pos_in == '0) begin
         sep_in = SEP_NEWLINE;
      end else if (req_end_of_message) begin
         sep_in = SEP_NONE;
      end else begin
         sep_in = SEP_COMMA;
      end
   end

   // Status towards the controller.
   assign sts.item_ok   = (req_letter_index < alphabet_size_ff);
   assign sts.no_nulls  = (nulls_in == '0);
   assign sts.last_null = (null_cnt_ff == DIGIT_W'(1));

   // Configuration writes and position updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_size_ff <= ALPHABET_W'(33);
         key_length_ff    <= KEY_LEN_REG_W'(1);
         key_letters_ff   <= '0;
         metre_length_ff  <= METRE_LEN_REG_W'(1);
         metre_digits_ff  <= '0;
         key_pos_ff       <= '0;
         metre_pos_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHABET_SIZE: alphabet_size_ff <= csr_wdata[ALPHABET_W-1:0];
               CSR_KEY_LENGTH:    key_length_ff    <= csr_wdata[KEY_LEN_REG_W-1:0];
               CSR_KEY_LETTERS:   key_letters_ff   <= csr_wdata[KEY_LETTERS_W-1:0];
               CSR_METRE_LENGTH:  metre_length_ff  <= csr_wdata[METRE_LEN_REG_W-1:0];
               CSR_METRE_DIGITS:  metre_digits_ff  <= csr_wdata[METRE_DIGITS_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.load && sts.item_ok) begin
            key_pos_ff   <= key_pos_in;
            metre_pos_ff <= metre_pos_in;
         end
      end
   end

   // Per-request payload and null counter.
   always_ff @(posedge clock) begin
      if (cmd.load && sts.item_ok) begin
         cipher_ff   <= cipher_in;
         sep_ff      <= sep_in;
         null_cnt_ff <= nulls_in;
      end else if (cmd.count) begin
         null_cnt_ff <= null_cnt_ff - DIGIT_W'(1);
      end
   end

   // Response payload: null tokens carry zero and a comma.
   assign rsp_cipher_index = cmd.show_letter ? cipher_ff : '0;
   assign rsp_separator    = cmd.show_letter ? sep_ff : SEP_COMMA;

endmodule

// File: hw/rtl/vigenere_cipher_with_metre_nulls.sv
// Top level of the Vigenere cipher that pads letters with metre-driven nulls.
// Each request carries one plaintext letter; the block answers with as many null
// tokens as the current metre digit (0 to 9) and then the cipher letter, one
// response per cycle while rsp_ready is high, from a single output stage. A request
// whose letter lies in the alphabet therefore occupies the output for its nulls and
// its letter, and the next request is taken in the same cycle as the cipher letter's
// response; a request outside the alphabet gives no response.
// Configuration is written through the csr port while no request is in flight.
`include "vigenere_cipher_with_metre_nulls_defines.svh"

module vigenere_cipher_with_metre_nulls #(
   parameter int MAX_KEY_LETTERS  = 10,
   parameter int MAX_METRE_DIGITS = 16,
   parameter int LETTER_BITS      = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [vcmn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vcmn_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vcmn_pkg::ALPHABET_W-1:0]   req_letter_index,
   input  logic                              req_end_of_message,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_token_kind,
   output logic [vcmn_pkg::ALPHABET_W-1:0]   rsp_cipher_index,
   output logic [vcmn_pkg::SEP_W-1:0]        rsp_separator,
   output logic                              rsp_last
);
   import vcmn_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer for null tokens and letters.
   vcmn_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .sts            (sts)
   );

   // Registers, positions and encipherment.
   vcmn_datapath #(
      .MAX_KEY_LETTERS  (MAX_KEY_LETTERS),
      .MAX_METRE_DIGITS (MAX_METRE_DIGITS),
      .LETTER_BITS      (LETTER_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_letter_index   (req_letter_index),
      .req_end_of_message (req_end_of_message),
      .rsp_cipher_index   (rsp_cipher_index),
      .rsp_separator      (rsp_separator),
      .cmd                (cmd),
      .sts                (sts)
   );

   // A request inside the alphabet always produces a response next cycle.
   `VCMN_ASSERT_NEXT(a_ok_gives_rsp, clock, reset, req_valid && req_ready && sts.item_ok, rsp_valid, "accepted letter gave no response")

   // A request outside the alphabet produces nothing.
   `VCMN_ASSERT_NEXT(a_bad_no_rsp, clock, reset, req_valid && req_ready && !sts.item_ok, !rsp_valid, "out-of-alphabet letter gave a response")

   // After the letter is taken with no new request, the output goes quiet.
   `VCMN_ASSERT_NEXT(a_letter_ends, clock, reset, rsp_valid && rsp_ready && rsp_last && !req_valid, !rsp_valid, "response after the final token")

   // Only the letter may carry a separator other than a comma.
   `VCMN_ASSERT_SAME(a_null_comma, clock, reset, rsp_valid && !rsp_token_kind, rsp_separator == SEP_COMMA && rsp_cipher_index == '0, "null token with payload")

endmodule

// File: test/vigenere_cipher_with_metre_nulls_tb.sv
// Self-checking testbench for the metre-null Vigenere cipher, with its own token predictor.
module vigenere_cipher_with_metre_nulls_tb;
   import vcmn_pkg::*;

   localparam int MAX_KEY_LETTERS  = 10;
   localparam int MAX_METRE_DIGITS = 16;
   localparam int LETTER_BITS      = 6;
   localparam int LONG_HOLD        = 300;
   localparam int SETTLE_CYCLES    = 20;
   localparam int CYCLE_LIMIT      = 600000;

   typedef struct {
      logic [ALPHABET_W-1:0] letter;
      logic                  eom;
   } letter_req_type;

   typedef struct {
      logic                  kind;
      logic [ALPHABET_W-1:0] index;
      logic [SEP_W-1:0]      sep;
      logic                  last;
   } cipher_token_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   csr_we             = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   logic [ALPHABET_W-1:0]  req_letter_index   = '0;
   logic                   req_end_of_message = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   logic                   rsp_token_kind;
   logic [ALPHABET_W-1:0]  rsp_cipher_index;
   logic [SEP_W-1:0]       rsp_separator;
   logic                   rsp_last;

   // Predictor copy of the registers and of the two running positions.
   logic [ALPHABET_W-1:0]      alpha_size   = 6'd33;
   logic [KEY_LEN_REG_W-1:0]   key_len      = 4'd1;
   logic [KEY_LETTERS_W-1:0]   key_letters  = '0;
   logic [METRE_LEN_REG_W-1:0] metre_len    = 5'd1;
   logic [METRE_DIGITS_W-1:0]  metre_digits = '0;
   logic [3:0]                 key_pos      = '0;
   logic [3:0]                 metre_pos    = '0;

   letter_req_type   pending_requests[$];
   cipher_token_type expected_tokens[$];
   letter_req_type   next_req;
   cipher_token_type want;

   int mismatches   = 0;
   int cycle_count  = 0;
   int send_gap     = 0;
   int recv_stall   = 0;
   int hold_asks    = 0;
   int hold_served  = 0;
   bit quiet        = 1'b0;

   vigenere_cipher_with_metre_nulls dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_letter_index   (req_letter_index),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_cipher_index   (rsp_cipher_index),
      .rsp_separator      (rsp_separator),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one, none while quiet.
   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Works out the tokens of one accepted request and advances both positions.
   function automatic void encipher_letter(input logic [ALPHABET_W-1:0] letter,
                                           input logic eom);
      int unsigned      klen, mlen, kpos, mpos, key, nulls, cipher;
      cipher_token_type tok;
      if (letter >= alpha_size) return;
      klen = (key_len == 0) ? 1 : ((key_len > MAX_KEY_LETTERS) ? MAX_KEY_LETTERS : key_len);
      mlen = (metre_len == 0) ? 1 :
             ((metre_len > MAX_METRE_DIGITS) ? MAX_METRE_DIGITS : metre_len);
      // A position left beyond a lowered length restarts at the first entry.
      kpos = (key_pos < klen) ? key_pos : 0;
      mpos = (metre_pos < mlen) ? metre_pos : 0;
      key = key_letters[kpos*LETTER_BITS +: LETTER_BITS];
      if (key >= alpha_size) key = 0;
      nulls = metre_digits[mpos*DIGIT_W +: DIGIT_W];
      if (nulls > NULLS_MAX) nulls = NULLS_MAX;
      cipher = letter + key;
      if (cipher >= alpha_size) cipher = cipher - alpha_size;
      kpos = (kpos + 1 >= klen) ? 0 : kpos + 1;
      mpos = (mpos + 1 >= mlen) ? 0 : mpos + 1;
      repeat (nulls) begin
         tok.kind  = 1'b0;
         tok.index = '0;
         tok.sep   = SEP_COMMA;
         tok.last  = 1'b0;
         expected_tokens.push_back(tok);
      end
      tok.kind  = 1'b1;
      tok.index = cipher[ALPHABET_W-1:0];
      if (mpos == 0) tok.sep = SEP_NEWLINE;
      else if (eom) tok.sep = SEP_NONE;
      else tok.sep = SEP_COMMA;
      tok.last  = 1'b1;
      expected_tokens.push_back(tok);
      key_pos   = kpos[3:0];
      metre_pos = mpos[3:0];
   endfunction

   function automatic void check_field(input string field, input logic [7:0] expected,
                                       input logic [7:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
                  actual);
         mismatches++;
      end
   endfunction

   // Request driver: presents queued letters, predicting each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) encipher_letter(req_letter_index, req_end_of_message);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_req = pending_requests.pop_front();
               req_valid          <= 1'b1;
               req_letter_index   <= next_req.letter;
               req_end_of_message <= next_req.eom;
               send_gap           <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks every token taken and throttles the ready line.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected token, expected none, actual kind %0d index %0d",
                        $time, rsp_token_kind, rsp_cipher_index);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("cipher_index", want.index, rsp_cipher_index);
               check_field("separator", want.sep, rsp_separator);
               check_field("last", want.last, rsp_last);
            end
         end
         // A long hold asked for by the stimulus takes priority over random stalls.
         if (hold_served != hold_asks) begin
            hold_served <= hold_served + 1;
            recv_stall  <= LONG_HOLD;
            rsp_ready   <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            recv_stall <= pick_gap();
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_letter(input logic [ALPHABET_W-1:0] letter, input logic eom);
      letter_req_type item;
      item.letter = letter;
      item.eom    = eom;
      pending_requests.push_back(item);
   endtask

   // Waits until every request is taken and every token has arrived, then lets
   // the block settle, since an out-of-alphabet request leaves no token behind.
   task automatic drain_block();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_tokens.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ALPHABET_SIZE: alpha_size   = data[ALPHABET_W-1:0];
         CSR_KEY_LENGTH:    key_len      = data[KEY_LEN_REG_W-1:0];
         CSR_KEY_LETTERS:   key_letters  = data[KEY_LETTERS_W-1:0];
         CSR_METRE_LENGTH:  metre_len    = data[METRE_LEN_REG_W-1:0];
         CSR_METRE_DIGITS:  metre_digits = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] asize, input logic [CSR_DATA_W-1:0] klen,
                             input logic [CSR_DATA_W-1:0] kletters,
                             input logic [CSR_DATA_W-1:0] mlen,
                             input logic [CSR_DATA_W-1:0] mdigits);
      write_reg(CSR_ALPHABET_SIZE, asize);
      write_reg(CSR_KEY_LENGTH, klen);
      write_reg(CSR_KEY_LETTERS, kletters);
      write_reg(CSR_METRE_LENGTH, mlen);
      write_reg(CSR_METRE_DIGITS, mdigits);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // One phase of random messages under a random setting; only letters inside
   // the alphabet count towards the phase length.
   task automatic random_phase(input int n_letters, input bit calm, input bit long_hold);
      int                    counted;
      logic [ALPHABET_W-1:0] asize;
      logic [ALPHABET_W-1:0] letter;
      case ($urandom_range(0, 5))
         0:       asize = 6'd63;
         1:       asize = 6'd1;
         default: asize = ALPHABET_W'($urandom_range(2, 62));
      endcase
      set_config(CSR_DATA_W'(asize), CSR_DATA_W'($urandom_range(0, 15)), {$urandom, $urandom},
                 CSR_DATA_W'($urandom_range(0, 31)), {$urandom, $urandom});
      quiet = calm;
      if (long_hold) hold_asks++;
      counted = 0;
      while (counted < n_letters) begin
         if ($urandom_range(0, 6) == 0) letter = ALPHABET_W'($urandom_range(0, 63));
         else letter = ALPHABET_W'($urandom_range(0, asize - 1));
         if (letter < asize) counted++;
         queue_letter(letter, $urandom_range(0, 7) == 0);
      end
      drain_block();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: 33 letters, zero key, no nulls, every letter ends a line.
      queue_letter(6'd0, 1'b0);
      queue_letter(6'd32, 1'b1);
      queue_letter(6'd33, 1'b0);
      queue_letter(6'd63, 1'b1);
      drain_block();

      // Key letter outside the alphabet, metre digits zero, nine and saturating.
      set_config(26, 3, {46'd0, 6'd40, 6'd25, 6'd3}, 4, {48'd0, 4'd2, 4'd15, 4'd9, 4'd0});
      queue_letter(6'd0, 1'b0);
      queue_letter(6'd25, 1'b0);
      queue_letter(6'd26, 1'b0);
      queue_letter(6'd63, 1'b1);
      queue_letter(6'd10, 1'b1);
      queue_letter(6'd5, 1'b0);
      queue_letter(6'd7, 1'b1);
      queue_letter(6'd12, 1'b1);
      drain_block();

      // Widest alphabet, zero lengths acting as one, all digits at fifteen.
      set_config(63, 0, {4'd0, {10{6'd62}}}, 0, {64{1'b1}});
      queue_letter(6'd62, 1'b1);
      queue_letter(6'd63, 1'b0);
      queue_letter(6'd0, 1'b0);
      drain_block();

      // One-letter alphabet, oversized lengths clamped, every key letter too big.
      set_config(1, 15, {64{1'b1}}, 31, 64'h0123_4567_89AB_CDEF);
      queue_letter(6'd0, 1'b0);
      queue_letter(6'd1, 1'b1);
      queue_letter(6'd0, 1'b1);
      drain_block();

      // Empty alphabet: nothing comes out whatever the letter.
      set_config(0, 10, 64'h0FED_CBA9_8765_4321, 16, 64'h9876_5432_1098_7654);
      queue_letter(6'd0, 1'b1);
      queue_letter(6'd63, 1'b0);
      drain_block();

      random_phase(45, 1'b1, 1'b0);
      random_phase(45, 1'b0, 1'b1);
      random_phase(45, 1'b0, 1'b0);
      random_phase(45, 1'b0, 1'b0);
      random_phase(45, 1'b1, 1'b0);
      random_phase(45, 1'b0, 1'b0);

      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
